@@ rtl/core/bblc_pkg.sv @@
package bblc_pkg;

    localparam int unsigned PERIOD_SLOTS_DEF = 100;

    localparam int unsigned DUTY_W  = 7;
    localparam int unsigned TIMER_W = 24;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned LIM_W   = 16;
    localparam int unsigned CFG_AW  = 2;
    localparam int unsigned CFG_DW  = 24;
    localparam int unsigned IN_DW   = 8;
    localparam int unsigned OUT_DW  = 48;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    localparam logic [LIM_W-1:0]   LONG_PRESS_RST  = 16'd2000;
    localparam logic [LIM_W-1:0]   RESET_PRESS_RST = 16'd5000;
    localparam logic [TIMER_W-1:0] IDLE_RESET_RST  = 24'd60000;

    typedef enum logic [CFG_AW-1:0] {
        REG_LONG_PRESS  = 2'd0,
        REG_RESET_PRESS = 2'd1,
        REG_IDLE_RESET  = 2'd2
    } t_reg_idx;

    function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
        logic [TIMER_W-1:0] r;
        r = (v == TIMER_MAX) ? TIMER_MAX : v + 1'b1;
        return r;
    endfunction

endpackage

@@ rtl/core/button_breathing_led_controller.sv @@
// Button-driven breathing LED controller.
// Slave stream: one word per PWM slot tick, tdata[0] is the button level
// (1 pressed), remaining tdata bits are zero fill.
// Master stream: one word per accepted tick, tdata from bit 0 up: led_on,
// reset_request, release_event, press_duration_ms[23:0], long_press,
// press_count[7:0], breathing_mode, duty_now[6:0], zero fill.
// Config channel: i_cfg_addr 0 long press limit, 1 reset press limit,
// 2 idle limit; writes always accepted, write only while no word is in flight.
// Path: a word accepted on the slave side enters the input register, then the
// result register, which drives the master side. One word per cycle while the
// receiver does not stall; the per-tick update is combinational logic between the two registers.
// Reset: all timers, counters and mode clear, limits return to defaults.
// Receiver stall: the result register holds its word, the input register
// holds one more, then o_s_axis_tready drops until the master side drains.
// A reset request clears all state except the limit registers.
module button_breathing_led_controller #(
    parameter int unsigned PERIOD_SLOTS = bblc_pkg::PERIOD_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [0] button_pressed, [7:1] zero
    input  logic [bblc_pkg::IN_DW-1:0]    i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [0] led_on, [1] reset_request, [2] release_event,
    // [26:3] press_duration_ms, [27] long_press, [35:28] press_count,
    // [36] breathing_mode, [43:37] duty_now, [47:44] zero
    output logic [bblc_pkg::OUT_DW-1:0]   o_m_axis_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bblc_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [bblc_pkg::CFG_DW-1:0]   i_cfg_data
);
    import bblc_pkg::*;

    localparam int unsigned SLOT_W = (PERIOD_SLOTS > 1) ? $clog2(PERIOD_SLOTS) : 1;
    localparam logic [SLOT_W:0]   SLOT_LAST = (SLOT_W+1)'(PERIOD_SLOTS - 1);
    localparam logic [DUTY_W-1:0] DUTY_TOP  = DUTY_W'(PERIOD_SLOTS);

    logic [LIM_W-1:0]   r_long_lim;
    logic [LIM_W-1:0]   r_reset_lim;
    logic [TIMER_W-1:0] r_idle_lim;

    logic               r_in_valid;
    logic               r_in_pressed;
    logic               r_out_valid;
    logic [OUT_DW-1:0]  r_out_data;

    logic [SLOT_W-1:0]  r_slot;
    logic [DUTY_W-1:0]  r_duty;
    logic               r_ramp_down;
    logic               r_mode;
    logic               r_press;
    logic [TIMER_W-1:0] r_press_tmr;
    logic [TIMER_W-1:0] r_idle_tmr;
    logic [COUNT_W-1:0] r_count;
    logic [TIMER_W-1:0] r_last_dur;
    logic               r_last_long;

    logic [SLOT_W-1:0]  n_slot;
    logic [DUTY_W-1:0]  n_duty;
    logic               n_ramp_down;
    logic               n_mode;
    logic               n_press;
    logic [TIMER_W-1:0] n_press_tmr;
    logic [TIMER_W-1:0] n_idle_tmr;
    logic [COUNT_W-1:0] n_count;
    logic [TIMER_W-1:0] n_last_dur;
    logic               n_last_long;
    logic [OUT_DW-1:0]  n_out_data;

    logic advance;
    logic in_take;

    assign o_cfg_ready     = 1'b1;
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_comb begin
        logic               start;
        logic               rel;
        logic               req;
        logic               lit;
        logic               wrap;
        logic [SLOT_W:0]    slot_nx;
        logic [DUTY_W:0]    duty_up;
        logic [DUTY_W-1:0]  duty_dn;
        logic [TIMER_W-1:0] dur;
        logic               rel_ok;

        start   = r_in_pressed && !r_press;
        rel     = !r_in_pressed && r_press;
        dur     = r_press_tmr;
        rel_ok  = dur < {{(TIMER_W-LIM_W){1'b0}}, r_reset_lim};
        wrap    = 1'b0;
        slot_nx = '0;
        duty_up = '0;
        duty_dn = '0;

        n_slot      = r_slot;
        n_duty      = r_duty;
        n_ramp_down = r_ramp_down;
        n_mode      = r_mode;
        n_press     = r_press;
        n_press_tmr = r_press_tmr;
        n_idle_tmr  = r_idle_tmr;
        n_count     = r_count;
        n_last_dur  = r_last_dur;
        n_last_long = r_last_long;

        if (start) begin
            n_press    = 1'b1;
            n_press_tmr = '0;
            n_idle_tmr = '0;
            n_count    = r_count + 1'b1;
        end else if (rel) begin
            n_press     = 1'b0;
            n_press_tmr = '0;
            n_last_dur  = dur;
            n_last_long = dur >= {{(TIMER_W-LIM_W){1'b0}}, r_long_lim};
            if (rel_ok) begin
                n_mode = !r_mode;
                if (!r_mode) begin
                    n_duty      = '0;
                    n_ramp_down = 1'b0;
                end
            end
        end

        req = (rel && !rel_ok) || (n_idle_tmr > r_idle_lim);

        if (req) begin
            n_slot      = '0;
            n_duty      = '0;
            n_ramp_down = 1'b0;
            n_mode      = 1'b0;
            n_press     = 1'b0;
            n_press_tmr = '0;
            n_idle_tmr  = '0;
            n_count     = '0;
            n_last_dur  = '0;
            n_last_long = 1'b0;
        end

        lit = n_mode && (DUTY_W'(n_slot) < n_duty);

        n_out_data = {4'b0000, n_duty, n_mode, n_count, n_last_long, n_last_dur,
                      rel, req, lit};

        // advance slot; at period end step the idle timer, the press timer while pressed, and duty in breathing mode
        slot_nx = {1'b0, n_slot} + 1'b1;
        wrap    = {1'b0, n_slot} >= SLOT_LAST;
        n_slot  = wrap ? '0 : slot_nx[SLOT_W-1:0];
        if (wrap) begin
            if (n_press) begin
                n_press_tmr = sat_inc(n_press_tmr);
            end
            n_idle_tmr = sat_inc(n_idle_tmr);
            if (n_mode) begin
                if (!n_ramp_down) begin
                    duty_up = {1'b0, n_duty} + 1'b1;
                    if (duty_up >= {1'b0, DUTY_TOP}) begin
                        n_duty      = DUTY_TOP;
                        n_ramp_down = 1'b1;
                    end else begin
                        n_duty = duty_up[DUTY_W-1:0];
                    end
                end else begin
                    duty_dn = (n_duty != '0) ? n_duty - 1'b1 : n_duty;
                    n_duty  = duty_dn;
                    if (duty_dn == '0) begin
                        n_ramp_down = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_lim  <= LONG_PRESS_RST;
            r_reset_lim <= RESET_PRESS_RST;
            r_idle_lim  <= IDLE_RESET_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_LONG_PRESS:  r_long_lim  <= i_cfg_data[LIM_W-1:0];
                REG_RESET_PRESS: r_reset_lim <= i_cfg_data[LIM_W-1:0];
                REG_IDLE_RESET:  r_idle_lim  <= i_cfg_data[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_pressed <= i_s_axis_tdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_duty      <= '0;
            r_ramp_down <= 1'b0;
            r_mode      <= 1'b0;
            r_press     <= 1'b0;
            r_press_tmr <= '0;
            r_idle_tmr  <= '0;
            r_count     <= '0;
            r_last_dur  <= '0;
            r_last_long <= 1'b0;
        end else if (advance) begin
            r_slot      <= n_slot;
            r_duty      <= n_duty;
            r_ramp_down <= n_ramp_down;
            r_mode      <= n_mode;
            r_press     <= n_press;
            r_press_tmr <= n_press_tmr;
            r_idle_tmr  <= n_idle_tmr;
            r_count     <= n_count;
            r_last_dur  <= n_last_dur;
            r_last_long <= n_last_long;
        end
    end

`ifndef NO_ASSERTIONS
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_duty <= DUTY_TOP)
        else $error("duty above period");

    a_led_needs_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[0] |-> r_out_data[36])
        else $error("led lit outside breathing mode");

    a_req_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[1] |-> r_out_data[35:28] == '0 && !r_out_data[36]
            && r_out_data[26:3] == '0)
        else $error("reset request without cleared state");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready |=> r_out_valid && $stable(r_out_data)
            && $stable(r_count))
        else $error("result or state moved during stall");
`endif

endmodule
